[hw/rtl/xbdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbdc_pkg
// Shared types, constants and round helpers for the XTEA block decryptor.
// ----------------------------------------------------------------------------
package xbdc_pkg;

  // data widths
  localparam int WORD_W    = 32;
  localparam int BLOCK_W   = 2 * WORD_W;
  localparam int CFG_IDX_W = 4;
  localparam int KEY_SEL_W = 2;

  // cipher schedule
  localparam int               ROUNDS        = 48;
  localparam int               STAGES        = 2 * ROUNDS;
  localparam logic [WORD_W-1:0] DELTA        = 32'h9E37_79B9;
  localparam logic [WORD_W-1:0] SUM_INIT     = WORD_W'(ROUNDS) * DELTA;
  localparam int               KEY_SEL_SHIFT = 11;

  // plaintext patterns that get a verdict
  localparam logic [BLOCK_W-1:0] MATCH_A = 64'd420;
  localparam logic [BLOCK_W-1:0] MATCH_B = 64'd1337;

  // key words after reset
  localparam logic [WORD_W-1:0] KEY0_RESET = 32'h0000_AEF8;
  localparam logic [WORD_W-1:0] KEY1_RESET = 32'h0000_17FF;
  localparam logic [WORD_W-1:0] KEY2_RESET = 32'h0000_3137;
  localparam logic [WORD_W-1:0] KEY3_RESET = 32'h0000_0420;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0 = 4'd0,
    REG_KEY1 = 4'd1,
    REG_KEY2 = 4'd2,
    REG_KEY3 = 4'd3
  } cfg_reg_t;

  // verdict codes
  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_420  = 2'd1,
    VERDICT_1337 = 2'd2
  } verdict_t;

  // four key words, index 0 in the low slot
  typedef logic [3:0][WORD_W-1:0] key_bank_t;

  // one pipeline slot: a is the word mixed next, b the word updated next
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } stage_word_t;

  // xtea mixing function
  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  // running sum seen by half-round h of round r
  function automatic logic [WORD_W-1:0] stage_sum(input int unsigned r, input logic h);
    logic [WORD_W-1:0] steps;
    steps = WORD_W'(r) + WORD_W'(h);
    return SUM_INIT - steps * DELTA;
  endfunction

  // key index of half-round h of round r
  function automatic logic [KEY_SEL_W-1:0] stage_key_sel(input int unsigned r,
                                                        input logic h);
    logic [WORD_W-1:0] s;
    s = stage_sum(r, h);
    return h ? s[KEY_SEL_W-1:0] : s[KEY_SEL_SHIFT +: KEY_SEL_W];
  endfunction

endpackage

[hw/rtl/xbdc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbdc interfaces
// Valid/ready channels for cipher words, plain words and key writes.
// ----------------------------------------------------------------------------

// cipher word channel
interface xbdc_in_if
  import xbdc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [BLOCK_W-1:0] cipher_block;

  modport source (output valid, output cipher_block, input ready);
  modport sink   (input valid, input cipher_block, output ready);
endinterface

// plain word channel
interface xbdc_out_if
  import xbdc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [BLOCK_W-1:0] plain_block;
  logic [1:0]         verdict;

  modport source (output valid, output plain_block, output verdict, input ready);
  modport sink   (input valid, input plain_block, input verdict, output ready);
endinterface

// key write channel
interface xbdc_cfg_if
  import xbdc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/xtea_block_decrypt_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_block_decrypt_check
// XTEA decryption of 64-bit words with a verdict on the plaintext.
//
//   channel   dir   payload                      handshake
//   in_ch     in    cipher_block[63:0]           valid / ready
//   out_ch    out   plain_block[63:0], verdict   valid / ready
//   cfg_ch    in    index[3:0], data[31:0]       valid / ready (ready = 1)
//
// One word enters per cycle while the skid slot is empty; the pipeline has one
// register stage per half-round (96 for 48 rounds) plus the output register.
// Reset loads the default key and clears every valid bit. When out_ch stalls,
// one more word lands in a skid slot and then the whole pipeline holds until
// that slot drains.
// ----------------------------------------------------------------------------
module xtea_block_decrypt_check
  import xbdc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  xbdc_in_if.sink      in_ch,
  xbdc_out_if.source   out_ch,
  xbdc_cfg_if.sink     cfg_ch
);

  key_bank_t   keys;
  logic        en;
  stage_word_t pipe_w [0:STAGES];

  // key registers
  xbdc_key_regs u_key_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .keys  (keys)
  );

  // pipeline entry: v0 is mixed first, v1 updated first
  assign in_ch.ready = en;
  assign pipe_w[0]   = '{valid: in_ch.valid,
                         a:     in_ch.cipher_block[BLOCK_W-1:WORD_W],
                         b:     in_ch.cipher_block[WORD_W-1:0]};

  // half-round stages
  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    for (genvar h = 0; h < 2; h++) begin : g_half
      localparam int S = 2 * r + h;
      xbdc_round_stage u_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .keys    (keys),
        .sum_c   (stage_sum(r, 1'(h))),
        .key_sel (stage_key_sel(r, 1'(h))),
        .d_in    (pipe_w[S]),
        .d_out   (pipe_w[S+1])
      );
    end
  end

  // verdict and output buffering
  xbdc_out_buf u_out_buf (
    .clk   (clk),
    .rst_n (rst_n),
    .last  (pipe_w[STAGES]),
    .en    (en),
    .out   (out_ch)
  );

endmodule

[hw/rtl/xbdc_key_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbdc_key_regs
// Holds the four 32-bit key words written over the configuration channel.
// ----------------------------------------------------------------------------
module xbdc_key_regs
  import xbdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  xbdc_cfg_if.sink         cfg,
  output key_bank_t        keys
);

  key_bank_t keys_r;
  key_bank_t keys_nxt;

  // writes are always taken
  assign cfg.ready = 1'b1;

  // decode the register index, unknown indexes are dropped
  always_comb begin
    keys_nxt = keys_r;
    if (cfg.valid) begin
      case (cfg.index)
        REG_KEY0: keys_nxt[0] = cfg.data;
        REG_KEY1: keys_nxt[1] = cfg.data;
        REG_KEY2: keys_nxt[2] = cfg.data;
        REG_KEY3: keys_nxt[3] = cfg.data;
        default:  keys_nxt    = keys_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= {KEY3_RESET, KEY2_RESET, KEY1_RESET, KEY0_RESET};
    end else begin
      keys_r <= keys_nxt;
    end
  end

  assign keys = keys_r;

endmodule

[hw/rtl/xbdc_round_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbdc_round_stage
// One registered half-round: b -= mix(a) ^ (sum + key), then the words swap.
// ----------------------------------------------------------------------------
module xbdc_round_stage
  import xbdc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  key_bank_t            keys,
  input  logic [WORD_W-1:0]    sum_c,
  input  logic [KEY_SEL_W-1:0] key_sel,
  input  stage_word_t          d_in,
  output stage_word_t          d_out
);

  logic [WORD_W-1:0] round_key;
  logic [WORD_W-1:0] f_val;
  logic [WORD_W-1:0] upd;
  logic              valid_r;
  logic [WORD_W-1:0] a_r;
  logic [WORD_W-1:0] b_r;

  // half-round datapath
  assign round_key = sum_c + keys[key_sel];
  assign f_val     = mix(d_in.a) ^ round_key;
  assign upd       = d_in.b - f_val;

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= d_in.valid;
    end
  end

  // data words, swapped so the next stage mixes the word just updated
  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= upd;
      b_r <= d_in.a;
    end
  end

  assign d_out = '{valid: valid_r, a: a_r, b: b_r};

endmodule

[hw/rtl/xbdc_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbdc_out_buf
// Verdict compare, output register and skid slot; drives the pipeline enable.
// ----------------------------------------------------------------------------
module xbdc_out_buf
  import xbdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  stage_word_t last,
  output logic        en,
  xbdc_out_if.source  out
);

  logic               incoming;
  logic               take;
  logic [BLOCK_W-1:0] new_plain;
  verdict_t           new_verdict;

  logic               out_v_r,       out_v_nxt;
  logic [BLOCK_W-1:0] out_plain_r,   out_plain_nxt;
  verdict_t           out_verdict_r, out_verdict_nxt;
  logic               skid_v_r,      skid_v_nxt;
  logic [BLOCK_W-1:0] skid_plain_r,  skid_plain_nxt;
  verdict_t           skid_verdict_r, skid_verdict_nxt;

  // pipeline moves while the skid slot is free
  assign en       = !skid_v_r;
  assign incoming = en && last.valid;
  assign take     = !out_v_r || out.ready;

  // plaintext judge
  assign new_plain = {last.a, last.b};
  always_comb begin
    if (new_plain == MATCH_A) begin
      new_verdict = VERDICT_420;
    end else if (new_plain == MATCH_B) begin
      new_verdict = VERDICT_1337;
    end else begin
      new_verdict = VERDICT_NONE;
    end
  end

  // output slot and skid slot update
  always_comb begin
    out_v_nxt        = out_v_r;
    out_plain_nxt    = out_plain_r;
    out_verdict_nxt  = out_verdict_r;
    skid_v_nxt       = skid_v_r;
    skid_plain_nxt   = skid_plain_r;
    skid_verdict_nxt = skid_verdict_r;
    if (take) begin
      if (skid_v_r) begin
        out_v_nxt       = 1'b1;
        out_plain_nxt   = skid_plain_r;
        out_verdict_nxt = skid_verdict_r;
        skid_v_nxt      = 1'b0;
      end else begin
        out_v_nxt       = incoming;
        out_plain_nxt   = new_plain;
        out_verdict_nxt = new_verdict;
      end
    end else if (incoming) begin
      skid_v_nxt       = 1'b1;
      skid_plain_nxt   = new_plain;
      skid_verdict_nxt = new_verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_plain_r    <= out_plain_nxt;
    out_verdict_r  <= out_verdict_nxt;
    skid_plain_r   <= skid_plain_nxt;
    skid_verdict_r <= skid_verdict_nxt;
  end

  assign out.valid       = out_v_r;
  assign out.plain_block = out_plain_r;
  assign out.verdict     = out_verdict_r;

endmodule

[hw/rtl/xbdc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbdc_checker
// Port-level checks on the decryptor's output and backpressure behavior.
// ----------------------------------------------------------------------------
module xbdc_checker
  import xbdc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [BLOCK_W-1:0] plain_block,
  input logic [1:0]         verdict
);

  // input side only blocks after the output was held in the previous cycle
  a_ready_after_free: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(out_valid && !out_ready) |-> in_ready)
    else $error("in_ready low without a stalled output word");

  // verdict agrees with the plaintext
  a_verdict_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((verdict == VERDICT_420) == (plain_block == MATCH_A)) &&
                  ((verdict == VERDICT_1337) == (plain_block == MATCH_B)))
    else $error("verdict does not match plain word");

  // held word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // held word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(plain_block) && $stable(verdict))
    else $error("output payload changed while stalled");

endmodule

bind xtea_block_decrypt_check xbdc_checker u_xbdc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .plain_block (out_ch.plain_block),
  .verdict     (out_ch.verdict)
);
